// ----- design/uld_pkg.sv -----
// uld_pkg: shared types and constants for the usage list difference block
// no dependencies; used by uld_ctrl, uld_dp and usage_list_difference
package uld_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int USAGE_W = 16;

    typedef struct packed {
        logic [USAGE_W-1:0] prev_usage;
        logic [USAGE_W-1:0] cur_usage;
        logic               last_item;
    } t_req;

    typedef struct packed {
        logic [USAGE_W-1:0] make_usage;
        logic [USAGE_W-1:0] break_usage;
        logic               last_result;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;     // request accepted, write both stores
        logic cmp;      // compare one position against the other list
        logic rd;       // fetch one result into the output register
        logic pop;      // result taken downstream
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic load_end;  // the request being loaded closes the run
        logic cmp_last;  // compare pass is at the final position
        logic emit_last; // output register holds the final result
    } t_sts;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_CMP  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

endpackage

// ----- design/uld_ctrl.sv -----
// uld_ctrl: sequencer for load, compare and emit phases
// depends on uld_pkg for command, status and state types
module uld_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_out_ready,
    input  uld_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output uld_pkg::t_cmd o_cmd
);

    uld_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= uld_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            uld_pkg::S_LOAD: begin
                if (i_valid && i_sts.load_end) n_state = uld_pkg::S_CMP;
            end
            uld_pkg::S_CMP: begin
                if (i_sts.cmp_last) n_state = uld_pkg::S_RD;
            end
            uld_pkg::S_RD: begin
                n_state = uld_pkg::S_OUT;
            end
            uld_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.emit_last ? uld_pkg::S_LOAD : uld_pkg::S_RD;
                end
            end
            default: n_state = uld_pkg::S_LOAD;
        endcase
    end

    assign o_in_ready  = (r_state == uld_pkg::S_LOAD);
    assign o_out_valid = (r_state == uld_pkg::S_OUT);

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = o_in_ready && i_valid;
        o_cmd.cmp  = (r_state == uld_pkg::S_CMP);
        o_cmd.rd   = (r_state == uld_pkg::S_RD);
        o_cmd.pop  = o_out_valid && i_out_ready;
    end

endmodule

// ----- design/uld_dp.sv -----
// uld_dp: list stores, parallel compare lanes, packed result lists
// depends on uld_pkg for payload, command and status types
module uld_dp #(
    parameter int LIST_DEPTH = uld_pkg::LIST_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  uld_pkg::t_req i_req,
    input  uld_pkg::t_cmd i_cmd,
    output uld_pkg::t_sts o_sts,
    output uld_pkg::t_rsp o_rsp
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int UW = uld_pkg::USAGE_W;

    logic [UW-1:0] r_prev [LIST_DEPTH];
    logic [UW-1:0] r_cur  [LIST_DEPTH];
    logic [UW-1:0] r_mk_mem [LIST_DEPTH];
    logic [UW-1:0] r_bk_mem [LIST_DEPTH];

    logic [AW-1:0] r_cnt, r_last, r_i, r_idx;
    logic [CW-1:0] r_plen, r_clen, r_mk, r_bk;
    logic          r_pdone, r_cdone;
    uld_pkg::t_rsp r_rsp;

    logic [UW-1:0] w_p_i, w_c_i;
    logic          w_c_in_prev, w_p_in_cur, w_mk_wr, w_bk_wr;

    // current entry of the compare pass against every live entry of the other list
    always_comb begin
        w_p_i       = r_prev[r_i];
        w_c_i       = r_cur[r_i];
        w_c_in_prev = 1'b0;
        w_p_in_cur  = 1'b0;
        for (int j = 0; j < LIST_DEPTH; j++) begin
            if (CW'(j) < r_plen && r_prev[j] == w_c_i) w_c_in_prev = 1'b1;
            if (CW'(j) < r_clen && r_cur[j] == w_p_i)  w_p_in_cur  = 1'b1;
        end
        w_mk_wr = i_cmd.cmp && (CW'(r_i) < r_clen) && !w_c_in_prev;
        w_bk_wr = i_cmd.cmp && (CW'(r_i) < r_plen) && !w_p_in_cur;
    end

    always_comb begin
        o_sts           = '0;
        o_sts.load_end  = i_req.last_item || (r_cnt == AW'(LIST_DEPTH - 1));
        o_sts.cmp_last  = (r_i == r_last);
        o_sts.emit_last = r_rsp.last_result;
    end

    assign o_rsp = r_rsp;

    // store writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_prev[r_cnt] <= i_req.prev_usage;
            r_cur[r_cnt]  <= i_req.cur_usage;
        end
    end

    // packed result lists
    always_ff @(posedge i_clk) begin
        if (w_mk_wr) r_mk_mem[r_mk[AW-1:0]] <= w_c_i;
        if (w_bk_wr) r_bk_mem[r_bk[AW-1:0]] <= w_p_i;
    end

    // output register, zero past the packed count
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rsp.make_usage  <= (CW'(r_idx) < r_mk) ? r_mk_mem[r_idx] : '0;
            r_rsp.break_usage <= (CW'(r_idx) < r_bk) ? r_bk_mem[r_idx] : '0;
            r_rsp.last_result <= (r_idx == r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_last  <= '0;
            r_i     <= '0;
            r_idx   <= '0;
            r_plen  <= '0;
            r_clen  <= '0;
            r_mk    <= '0;
            r_bk    <= '0;
            r_pdone <= 1'b0;
            r_cdone <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                // live length runs up to the first zero
                if (!r_pdone) begin
                    if (i_req.prev_usage == '0) r_pdone <= 1'b1;
                    else                        r_plen  <= r_plen + 1'b1;
                end
                if (!r_cdone) begin
                    if (i_req.cur_usage == '0) r_cdone <= 1'b1;
                    else                       r_clen  <= r_clen + 1'b1;
                end
                if (o_sts.load_end) begin
                    r_last <= r_cnt;
                    r_i    <= '0;
                    r_idx  <= '0;
                    r_mk   <= '0;
                    r_bk   <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.cmp) begin
                r_i <= r_i + 1'b1;
                if (w_mk_wr) r_mk <= r_mk + 1'b1;
                if (w_bk_wr) r_bk <= r_bk + 1'b1;
            end
            if (i_cmd.pop) begin
                if (r_rsp.last_result) begin
                    r_cnt   <= '0;
                    r_plen  <= '0;
                    r_clen  <= '0;
                    r_pdone <= 1'b0;
                    r_cdone <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

endmodule

// ----- design/usage_list_difference.sv -----
// usage_list_difference: one request per cycle while loading; the closing request
// starts the compare phase (one position per cycle against all live entries),
// then each loaded position gives one result, fetched into the output register
// and then presented until it is taken downstream
// synchronous active-low reset returns to loading at position 0, lists empty
// depends on uld_pkg, uld_ctrl, uld_dp
module usage_list_difference #(
    parameter int LIST_DEPTH = uld_pkg::LIST_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  uld_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output uld_pkg::t_rsp o_rsp
);

    uld_pkg::t_cmd w_cmd;
    uld_pkg::t_sts w_sts;

    uld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_out_ready (i_ready),
        .i_sts       (w_sts),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .o_cmd       (w_cmd)
    );

    uld_dp #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_rsp   (o_rsp)
    );

endmodule
